/* rtl/core/tll_pkg.sv */
package tll_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int RAM_AW        = IDX_W + 1;
	localparam int RAM_DEPTH     = 2 * (1 << IDX_W);
	localparam int TIME_W        = 32;
	localparam int TAG_W         = 16;
	localparam int ENTRY_W       = TIME_W + TAG_W;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_MISS = 2'd2;

endpackage

/* rtl/core/tll_if.sv */
interface tll_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic        track;
	logic [31:0] time_ms;
	logic [15:0] line_tag;

	modport source (output valid, action, track, time_ms, line_tag, input ready);
	modport sink   (input valid, action, track, time_ms, line_tag, output ready);
endinterface

interface tll_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] found_tag;
	logic [7:0]  found_index;
	logic [31:0] line_length_ms;
	logic        open_ended;
	logic        new_line;

	modport source (output valid, status, found_tag, found_index, line_length_ms,
		open_ended, new_line, input ready);
	modport sink   (input valid, status, found_tag, found_index, line_length_ms,
		open_ended, new_line, output ready);
endinterface

/* rtl/core/timed_line_table_lookup.sv */
// Clear and unknown actions go straight to the result register; lookup runs a binary
// search, each probe a read and a compare (one shared RAM read port, one compare unit),
// then reads the found entry and its successor; insert searches, shifts entries up, writes.
// One item at a time: the next beat is taken the cycle after the result is registered;
// a result still waiting on rsp holds the following item before its output.
// arst_n clears counts, last-line state, offsets and handshakes; table RAM is not cleared.
module timed_line_table_lookup
	import tll_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tll_req_if.sink            req,
	tll_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_PROBE, S_CMP, S_SHIFT, S_WNEW, S_LFETCH, S_LNEXT, S_LLAST, S_FINISH
	} state_t;

	state_t             st_q;
	logic [1:0]         act_q;
	logic               trk_q;
	logic [TIME_W-1:0]  time_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CNT_W-1:0]   lo_q, hi_q, k_q;
	logic [IDX_W-1:0]   mid_q, m_q, pend_idx_q;
	logic               pend_q;
	logic [TIME_W-1:0]  start_m_q;
	logic [CNT_W-1:0]   count_q [2];
	logic [7:0]         prev_idx_q [2];
	logic               prev_valid_q [2];
	logic [31:0]        offset_q [2];

	logic [1:0]         res_status_q;
	logic [15:0]        res_tag_q;
	logic [7:0]         res_index_q;
	logic [31:0]        res_len_q;
	logic               res_open_q;
	logic               res_changed_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [15:0]        out_tag_q;
	logic [7:0]         out_index_q;
	logic [31:0]        out_len_q;
	logic               out_open_q;
	logic               out_changed_q;

	logic [CNT_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid;
	logic [IDX_W-1:0]   rd_idx;
	logic               ram_we;
	logic [RAM_AW-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [TIME_W-1:0]  rd_start;
	logic [TAG_W-1:0]   rd_tag;
	logic [33:0]        cmp_offset;
	logic [33:0]        eff_start;
	logic [33:0]        cmp_key;
	logic               greater;
	logic               accept;
	logic               out_free;
	logic               cfg_wr;
	logic [7:0]         m_idx8;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign m_idx8  = 8'(m_q);

	always_comb begin
		case (st_q)
			S_PROBE:  rd_idx = mid;
			S_SHIFT:  rd_idx = IDX_W'(k_q - CNT_W'(1));
			S_LFETCH: rd_idx = m_q;
			S_LNEXT:  rd_idx = IDX_W'(CNT_W'(m_q) + CNT_W'(1));
			default:  rd_idx = '0;
		endcase
	end

	assign ram_we    = pend_q || (st_q == S_WNEW);
	assign ram_waddr = pend_q ? {trk_q, pend_idx_q} : {trk_q, IDX_W'(lo_q)};
	assign ram_wdata = pend_q ? ram_rdata : {time_q, tag_q};
	assign rd_start  = ram_rdata[ENTRY_W-1:TAG_W];
	assign rd_tag    = ram_rdata[TAG_W-1:0];

	tll_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr({trk_q, rd_idx}),
		.rdata(ram_rdata)
	);

	// shared compare: start + offset (lookups only) against time, signed, no wrap
	assign cmp_offset = (act_q == ACT_LOOKUP) ? {{2{offset_q[trk_q][31]}}, offset_q[trk_q]} : '0;
	assign eff_start  = {2'b00, rd_start} + cmp_offset;
	assign cmp_key    = {2'b00, time_q};
	assign greater    = $signed(eff_start) > $signed(cmp_key);

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign cfg_wr   = psel && penable && pwrite;

	assign req.ready = (st_q == S_IDLE);
	assign pready    = 1'b1;
	assign prdata    = offset_q[paddr[2]];

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_tag      = out_tag_q;
	assign rsp.found_index    = out_index_q;
	assign rsp.line_length_ms = out_len_q;
	assign rsp.open_ended     = out_open_q;
	assign rsp.new_line       = out_changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_IDLE;
			act_q         <= ACT_NONE;
			trk_q         <= 1'b0;
			time_q        <= '0;
			tag_q         <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			k_q           <= '0;
			mid_q         <= '0;
			m_q           <= '0;
			pend_q        <= 1'b0;
			pend_idx_q    <= '0;
			start_m_q     <= '0;
			count_q       <= '{default: '0};
			prev_idx_q    <= '{default: '0};
			prev_valid_q  <= '{default: 1'b0};
			offset_q      <= '{default: '0};
			res_status_q  <= STS_OK;
			res_tag_q     <= '0;
			res_index_q   <= '0;
			res_len_q     <= '0;
			res_open_q    <= 1'b0;
			res_changed_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_status_q  <= STS_OK;
			out_tag_q     <= '0;
			out_index_q   <= '0;
			out_len_q     <= '0;
			out_open_q    <= 1'b0;
			out_changed_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				offset_q[paddr[2]] <= pwdata;
			end

			pend_q <= (st_q == S_SHIFT) && (k_q > lo_q);

			if (rsp.valid && rsp.ready && (st_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (accept) begin
						act_q         <= req.action;
						trk_q         <= req.track;
						time_q        <= req.time_ms;
						tag_q         <= req.line_tag;
						lo_q          <= '0;
						hi_q          <= count_q[req.track];
						res_status_q  <= ((req.action == ACT_INSERT) &&
							(count_q[req.track] >= CNT_W'(TABLE_ENTRIES))) ? STS_FULL : STS_OK;
						res_tag_q     <= '0;
						res_index_q   <= '0;
						res_len_q     <= '0;
						res_open_q    <= 1'b0;
						res_changed_q <= 1'b0;
						case (req.action)
							ACT_CLEAR: begin
								count_q[req.track]      <= '0;
								prev_valid_q[req.track] <= 1'b0;
								st_q                    <= S_FINISH;
							end
							ACT_INSERT: begin
								if (count_q[req.track] >= CNT_W'(TABLE_ENTRIES)) begin
									st_q <= S_FINISH;
								end else begin
									st_q <= S_PROBE;
								end
							end
							ACT_LOOKUP: st_q <= S_PROBE;
							default:    st_q <= S_FINISH;
						endcase
					end
				end
				S_PROBE: begin
					if (lo_q < hi_q) begin
						mid_q <= mid;
						st_q  <= S_CMP;
					end else if (act_q == ACT_INSERT) begin
						k_q  <= count_q[trk_q];
						st_q <= S_SHIFT;
					end else if (lo_q == '0) begin
						res_status_q <= STS_MISS;
						st_q         <= S_FINISH;
					end else begin
						m_q  <= IDX_W'(lo_q - CNT_W'(1));
						st_q <= S_LFETCH;
					end
				end
				S_CMP: begin
					if (greater) begin
						hi_q <= CNT_W'(mid_q);
					end else begin
						lo_q <= CNT_W'(mid_q) + CNT_W'(1);
					end
					st_q <= S_PROBE;
				end
				S_SHIFT: begin
					if (k_q > lo_q) begin
						pend_idx_q <= IDX_W'(k_q);
						k_q        <= k_q - CNT_W'(1);
					end else begin
						st_q <= S_WNEW;
					end
				end
				S_WNEW: begin
					count_q[trk_q]      <= count_q[trk_q] + CNT_W'(1);
					prev_valid_q[trk_q] <= 1'b0;
					st_q                <= S_FINISH;
				end
				S_LFETCH: st_q <= S_LNEXT;
				S_LNEXT: begin
					start_m_q           <= rd_start;
					res_tag_q           <= rd_tag;
					res_index_q         <= m_idx8;
					res_changed_q       <= !prev_valid_q[trk_q] || (prev_idx_q[trk_q] != m_idx8);
					prev_idx_q[trk_q]   <= m_idx8;
					prev_valid_q[trk_q] <= 1'b1;
					if ((CNT_W'(m_q) + CNT_W'(1)) < count_q[trk_q]) begin
						st_q <= S_LLAST;
					end else begin
						res_open_q <= 1'b1;
						st_q       <= S_FINISH;
					end
				end
				S_LLAST: begin
					res_len_q <= rd_start - start_m_q;
					st_q      <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_tag_q     <= res_tag_q;
						out_index_q   <= res_index_q;
						out_len_q     <= res_len_q;
						out_open_q    <= res_open_q;
						out_changed_q <= res_changed_q;
						st_q          <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/tll_ram.sv */
module tll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sim/tb.sv */
module tb;
	import tll_pkg::*;

	localparam logic [PADDR_W-1:0] REG_OFFSET_ZERO = PADDR_W'(0);
	localparam logic [PADDR_W-1:0] REG_OFFSET_ONE  = PADDR_W'(4);

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_tag;
		logic [7:0]  found_index;
		logic [31:0] line_length;
		logic        open_ended;
		logic        new_line;
	} line_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	tll_req_if req_ch ();
	tll_rsp_if rsp_ch ();

	timed_line_table_lookup dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the line tables
	logic [31:0]        line_start [2][TABLE_ENTRIES];
	logic [15:0]        line_label [2][TABLE_ENTRIES];
	int                 line_count [2];
	logic [7:0]         last_index [2];
	logic               last_valid [2];
	logic signed [31:0] track_offset [2];

	line_result_t expected_lines[$];
	int           error_count = 0;
	bit           sender_idle = 1'b1;
	bit           sink_idle = 1'b1;
	int           long_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic line_result_t predict_line(logic [1:0] act, logic trk,
			logic [31:0] t_ms, logic [15:0] tag);
		line_result_t r;
		int n, pos, k, m;
		longint shift, key;
		r = '0;
		n = line_count[trk];
		case (act)
			ACT_CLEAR: begin
				line_count[trk] = 0;
				last_valid[trk] = 1'b0;
			end
			ACT_INSERT: begin
				if (n >= TABLE_ENTRIES) begin
					r.status = STS_FULL;
				end else begin
					pos = 0;
					while (pos < n && line_start[trk][pos] <= t_ms)
						pos++;
					for (k = n; k > pos; k--) begin
						line_start[trk][k] = line_start[trk][k-1];
						line_label[trk][k] = line_label[trk][k-1];
					end
					line_start[trk][pos] = t_ms;
					line_label[trk][pos] = tag;
					line_count[trk] = n + 1;
					last_valid[trk] = 1'b0;
				end
			end
			ACT_LOOKUP: begin
				shift = track_offset[trk];
				key = longint'({32'd0, t_ms});
				pos = 0;
				while (pos < n && longint'({32'd0, line_start[trk][pos]}) + shift <= key)
					pos++;
				if (pos == 0) begin
					r.status = STS_MISS;
				end else begin
					m = pos - 1;
					r.found_tag = line_label[trk][m];
					r.found_index = 8'(m);
					if (m + 1 < n)
						r.line_length = line_start[trk][m+1] - line_start[trk][m];
					else
						r.open_ended = 1'b1;
					r.new_line = !last_valid[trk] || last_index[trk] != 8'(m);
					last_index[trk] = 8'(m);
					last_valid[trk] = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic string show_line(line_result_t r);
		return $sformatf("sts %0d tag %h idx %0d len %h open %b chg %b", r.status,
			r.found_tag, r.found_index, r.line_length, r.open_ended, r.new_line);
	endfunction

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin : line_checker
		line_result_t got, want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.status, rsp_ch.found_tag, rsp_ch.found_index,
				rsp_ch.line_length_ms, rsp_ch.open_ended, rsp_ch.new_line};
			if (expected_lines.size() == 0) begin
				flag_error({"unexpected result beat: ", show_line(got)});
			end else begin
				want = expected_lines.pop_front();
				if (got.status !== want.status || got.found_tag !== want.found_tag ||
						got.found_index !== want.found_index ||
						got.line_length !== want.line_length ||
						got.open_ended !== want.open_ended ||
						got.new_line !== want.new_line)
					flag_error({"expected ", show_line(want), ", got ", show_line(got)});
			end
		end
	end

	initial begin : result_sink
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (long_hold - 1) @(posedge clk);
				long_hold = 0;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic [1:0] act, logic trk, logic [31:0] t_ms,
			logic [15:0] tag);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.track    <= trk;
		req_ch.time_ms  <= t_ms;
		req_ch.line_tag <= tag;
		do @(posedge clk); while (!req_ch.ready);
		expected_lines.push_back(predict_line(act, trk, t_ms, tag));
	endtask

	task automatic send_random_item();
		logic [1:0]  act;
		logic [31:0] t_ms;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 3)
			act = ACT_CLEAR;
		else if (r < 5)
			act = ACT_NONE;
		else if (r < 50)
			act = ACT_INSERT;
		else
			act = ACT_LOOKUP;
		case ($urandom_range(0, 7))
			0: t_ms = $urandom();
			1: t_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			default: t_ms = $urandom_range(0, 6000);
		endcase
		send_item(act, 1'($urandom_range(0, 1)), t_ms, 16'($urandom()));
	endtask

	task automatic wait_results();
		req_ch.valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
	endtask

	// leaves psel high so that transfers can follow back to back
	task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic check_offsets();
		logic [31:0] back;
		apb_access(1'b0, REG_OFFSET_ZERO, '0, back);
		if (back !== track_offset[0])
			flag_error($sformatf("offset zero reads %h, expected %h", back, track_offset[0]));
		apb_access(1'b0, REG_OFFSET_ONE, '0, back);
		if (back !== track_offset[1])
			flag_error($sformatf("offset one reads %h, expected %h", back, track_offset[1]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_offsets(logic [31:0] zero_val, logic [31:0] one_val);
		logic [31:0] back;
		wait_results();
		apb_access(1'b1, REG_OFFSET_ZERO, zero_val, back);
		apb_access(1'b1, REG_OFFSET_ONE, one_val, back);
		track_offset[0] = zero_val;
		track_offset[1] = one_val;
		check_offsets();
	endtask

	task automatic test_directed();
		send_item(ACT_LOOKUP, 1'b0, 32'd0, 16'h0);
		send_item(ACT_NONE, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(ACT_CLEAR, 1'b1, 32'd0, 16'h0);
		send_item(ACT_INSERT, 1'b0, 32'd100, 16'h0000);
		send_item(ACT_INSERT, 1'b0, 32'd100, 16'h0002);
		send_item(ACT_INSERT, 1'b0, 32'd300, 16'h0003);
		send_item(ACT_LOOKUP, 1'b0, 32'd150, 16'h0);
		send_item(ACT_LOOKUP, 1'b0, 32'd50, 16'h0);
		send_item(ACT_LOOKUP, 1'b0, 32'd299, 16'h0);
		send_item(ACT_LOOKUP, 1'b0, 32'd300, 16'h0);
		send_item(ACT_LOOKUP, 1'b0, 32'hFFFF_FFFF, 16'h0);
		send_item(ACT_INSERT, 1'b0, 32'd200, 16'h0004);
		send_item(ACT_LOOKUP, 1'b0, 32'd250, 16'h0);
		send_item(ACT_INSERT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(ACT_INSERT, 1'b1, 32'd0, 16'hAAAA);
		send_item(ACT_LOOKUP, 1'b1, 32'd0, 16'h0);
		send_item(ACT_LOOKUP, 1'b1, 32'hFFFF_FFFE, 16'h0);
		send_item(ACT_LOOKUP, 1'b1, 32'hFFFF_FFFF, 16'h0);
		send_item(ACT_CLEAR, 1'b0, 32'd0, 16'h0);
		send_item(ACT_LOOKUP, 1'b0, 32'd300, 16'h0);
		send_item(ACT_CLEAR, 1'b1, 32'd0, 16'h0);
		send_item(ACT_LOOKUP, 1'b1, 32'd0, 16'h0);
		send_item(ACT_INSERT, 1'b1, 32'd7, 16'h5555);
		send_item(ACT_LOOKUP, 1'b1, 32'd7, 16'h0);
	endtask

	task automatic test_full_table();
		int i;
		send_item(ACT_CLEAR, 1'b0, 32'd0, 16'h0);
		repeat (TABLE_ENTRIES)
			send_item(ACT_INSERT, 1'b0, $urandom_range(0, 600), 16'($urandom()));
		repeat (3)
			send_item(ACT_INSERT, 1'b0, $urandom(), 16'($urandom()));
		send_item(ACT_CLEAR, 1'b1, 32'd0, 16'h0);
		for (i = 0; i < TABLE_ENTRIES; i++)
			send_item(ACT_INSERT, 1'b1, 32'(i * 16), 16'($urandom()));
		send_item(ACT_INSERT, 1'b1, 32'd0, 16'h1234);
		repeat (20)
			send_item(ACT_LOOKUP, 1'($urandom_range(0, 1)), $urandom_range(0, 5000), 16'h0);
		send_item(ACT_LOOKUP, 1'b0, 32'hFFFF_FFFF, 16'h0);
		send_item(ACT_LOOKUP, 1'b1, 32'hFFFF_FFFF, 16'h0);
	endtask

	task automatic test_offsets();
		logic [31:0] zero_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0};
		logic [31:0] one_vals  [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0};
		int k;
		for (k = 0; k < 4; k++) begin
			program_offsets(zero_vals[k], one_vals[k]);
			send_item(ACT_LOOKUP, 1'b0, 32'd0, 16'h0);
			send_item(ACT_LOOKUP, 1'b1, 32'hFFFF_FFFF, 16'h0);
			repeat (20)
				send_random_item();
		end
	endtask

	task automatic test_backpressure();
		wait_results();
		long_hold = 300;
		repeat (40)
			send_random_item();
		wait_results();
	endtask

	task automatic test_random();
		int ph, z, o;
		for (ph = 0; ph < 6; ph++) begin
			z = 0;
			o = 0;
			if (ph == 4) begin
				z = $urandom();
				o = $urandom();
			end else if (ph != 0) begin
				z = $urandom_range(0, 8000) - 4000;
				o = $urandom_range(0, 8000) - 4000;
			end
			program_offsets(z, o);
			if (ph == 5) begin
				sender_idle = 1'b0;
				sink_idle = 1'b0;
			end
			repeat (180)
				send_random_item();
		end
	endtask

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.action   = ACT_CLEAR;
		req_ch.track    = 1'b0;
		req_ch.time_ms  = '0;
		req_ch.line_tag = '0;
		line_count   = '{0, 0};
		last_index   = '{8'd0, 8'd0};
		last_valid   = '{1'b0, 1'b0};
		track_offset = '{32'sd0, 32'sd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_offsets();
		@(posedge clk);
		test_directed();
		test_full_table();
		test_offsets();
		test_backpressure();
		test_random();

		wait_results();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/tll_pkg.sv
rtl/core/tll_if.sv
rtl/core/tll_ram.sv
rtl/core/timed_line_table_lookup.sv
sim/tb.sv
